/* sv/dtc_pkg.sv */
// Package with the shared types and constants of the door toggle controller.
`default_nettype none
package dtc_pkg;

   localparam int unsigned SuppressWidth = 20;
   localparam int unsigned PulseWidth    = 13;
   localparam int unsigned PressWidth    = 11;
   localparam int unsigned CsrIdxWidth   = 2;
   localparam int unsigned CsrDataWidth  = 20;

   localparam logic [PressWidth-1:0] PRESS_MIN = PressWidth'(30);
   localparam logic [PressWidth-1:0] PRESS_MAX = PressWidth'(1500);
   localparam logic [PressWidth-1:0] PRESS_SAT = {PressWidth{1'b1}};

   localparam logic [SuppressWidth-1:0] SUPPRESS_RESET = SuppressWidth'(10000);
   localparam logic [PulseWidth-1:0]    PULSE_RESET    = PulseWidth'(300);

   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_OPEN     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RADIO_PRESENT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SUPPRESS_MS   = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PULSE_MS      = 2'd3;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_OPEN  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;

   localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
   localparam logic [1:0] DOOR_OPEN    = 2'd1;
   localparam logic [1:0] DOOR_CLOSED  = 2'd2;

   localparam logic [1:0] SRC_NONE    = 2'd0;
   localparam logic [1:0] SRC_AUTO    = 2'd1;
   localparam logic [1:0] SRC_TRIGGER = 2'd2;
   localparam logic [1:0] SRC_BUTTON  = 2'd3;

   typedef struct packed {
      logic trigger_level;
      logic button_level;
      logic auto_open_req;
      logic auto_close_req;
      logic radio_accepted;
   } req_data_type;

   typedef struct packed {
      logic       send_open;
      logic       send_close;
      logic       relay_on;
      logic       status_led;
      logic [1:0] door_belief;
      logic [1:0] opener;
      logic       auto_refused;
   } rsp_data_type;

   typedef struct packed {
      logic [CsrIdxWidth-1:0]  index;
      logic [CsrDataWidth-1:0] wdata;
   } csr_data_type;

   typedef struct packed {
      logic                     hold_open;
      logic                     radio_present;
      logic [SuppressWidth-1:0] suppress_ms;
      logic [PulseWidth-1:0]    pulse_ms;
   } cfg_type;

endpackage
`default_nettype wire

/* sv/dtc_req_if.sv */
// Interface of the tick input channel.
`default_nettype none
interface dtc_req_if import dtc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/dtc_rsp_if.sv */
// Interface of the result channel.
`default_nettype none
interface dtc_rsp_if import dtc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/dtc_csr_if.sv */
// Interface of the configuration write channel.
`default_nettype none
interface dtc_csr_if import dtc_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/dtc_csr.sv */
// Configuration register bank of the door toggle controller.
`default_nettype none
module dtc_csr import dtc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtc_csr_if.sink   csr_if,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.data.index)
            CSR_HOLD_OPEN:     cfg_in.hold_open     = csr_if.data.wdata[0];
            CSR_RADIO_PRESENT: cfg_in.radio_present = csr_if.data.wdata[0];
            CSR_SUPPRESS_MS:   cfg_in.suppress_ms   = csr_if.data.wdata[SuppressWidth-1:0];
            CSR_PULSE_MS:      cfg_in.pulse_ms      = csr_if.data.wdata[PulseWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_open     <= 1'b0;
         cfg_ff.radio_present <= 1'b0;
         cfg_ff.suppress_ms   <= SUPPRESS_RESET;
         cfg_ff.pulse_ms      <= PULSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* sv/dtc_tick.sv */
// Per-tick decision logic and controller state of the door toggle controller.
`default_nettype none
module dtc_tick import dtc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  wire cfg_type      cfg,
   input  wire req_data_type req_data,
   output rsp_data_type      rsp_data
);

   logic                     trigger_prev_ff, trigger_prev_in;
   logic                     button_prev_ff, button_prev_in;
   logic [PressWidth-1:0]    press_ticks_ff, press_ticks_in;
   logic                     press_seen_ff, press_seen_in;
   logic [1:0]               door_ff, door_in;
   logic [1:0]               last_cmd_ff, last_cmd_in;
   logic [1:0]               opener_ff, opener_in;
   logic [SuppressWidth-1:0] suppress_left_ff, suppress_left_in;
   logic [PulseWidth-1:0]    pulse_left_ff, pulse_left_in;

   logic [PressWidth-1:0]    press_count;
   logic                     trig_fall, btn_press, btn_release, btn_ok;
   logic                     manual, want_close, auto_open_ok, auto_close_ok;
   logic                     issued, cmd_open, radio_ok;
   logic [PulseWidth-1:0]    pulse_len;

   always_comb begin
      press_count = press_ticks_ff;
      if (press_seen_ff && (press_ticks_ff != PRESS_SAT)) begin
         press_count = press_ticks_ff + PressWidth'(1);
      end

      trig_fall   = trigger_prev_ff & ~req_data.trigger_level;
      btn_press   = button_prev_ff & ~req_data.button_level;
      btn_release = ~button_prev_ff & req_data.button_level;
      btn_ok      = btn_release & press_seen_ff & (press_count > PRESS_MIN) &
                    (press_count < PRESS_MAX);
      want_close  = (last_cmd_ff == CMD_OPEN) ||
                    ((last_cmd_ff == CMD_NONE) && (door_ff == DOOR_OPEN));
      radio_ok    = cfg.radio_present & req_data.radio_accepted;
      pulse_len   = (cfg.pulse_ms == '0) ? PulseWidth'(1) : cfg.pulse_ms;

      trigger_prev_in  = trigger_prev_ff;
      button_prev_in   = button_prev_ff;
      press_ticks_in   = press_count;
      press_seen_in    = press_seen_ff;
      door_in          = door_ff;
      last_cmd_in      = last_cmd_ff;
      opener_in        = opener_ff;
      suppress_left_in = suppress_left_ff;
      pulse_left_in    = pulse_left_ff;

      manual        = 1'b0;
      auto_open_ok  = 1'b0;
      auto_close_ok = 1'b0;
      issued        = 1'b0;
      cmd_open      = 1'b0;

      rsp_data = '0;

      if (pulse_left_ff != '0) begin
         pulse_left_in     = pulse_left_ff - PulseWidth'(1);
         rsp_data.relay_on = 1'b1;
      end else begin
         if (suppress_left_ff != '0) begin
            suppress_left_in = suppress_left_ff - SuppressWidth'(1);
         end

         if (btn_press) begin
            press_ticks_in = '0;
            press_seen_in  = 1'b1;
         end else if (btn_release) begin
            press_ticks_in = '0;
            press_seen_in  = 1'b0;
         end
         trigger_prev_in = req_data.trigger_level;
         button_prev_in  = req_data.button_level;

         manual = trig_fall | btn_ok;

         if (manual) begin
            issued           = 1'b1;
            cmd_open         = ~want_close;
            door_in          = want_close ? DOOR_CLOSED : DOOR_OPEN;
            last_cmd_in      = want_close ? CMD_CLOSE : CMD_OPEN;
            opener_in        = trig_fall ? SRC_TRIGGER : SRC_BUTTON;
            suppress_left_in = cfg.suppress_ms;
         end else begin
            if (req_data.auto_open_req) begin
               if (cfg.hold_open || (suppress_left_in != '0)) begin
                  rsp_data.auto_refused = 1'b1;
               end else begin
                  auto_open_ok = 1'b1;
               end
            end
            if (auto_open_ok) begin
               issued      = 1'b1;
               cmd_open    = 1'b1;
               door_in     = DOOR_OPEN;
               last_cmd_in = CMD_OPEN;
               opener_in   = SRC_AUTO;
            end else if (req_data.auto_close_req) begin
               if (cfg.hold_open) begin
                  rsp_data.auto_refused = 1'b1;
               end else begin
                  auto_close_ok = 1'b1;
               end
            end
            if (auto_close_ok) begin
               issued      = 1'b1;
               door_in     = DOOR_CLOSED;
               last_cmd_in = CMD_CLOSE;
               opener_in   = SRC_NONE;
            end
         end

         if (issued) begin
            if (radio_ok) begin
               rsp_data.send_open  = cmd_open;
               rsp_data.send_close = ~cmd_open;
            end else begin
               pulse_left_in     = pulse_len - PulseWidth'(1);
               rsp_data.relay_on = 1'b1;
            end
         end
      end

      rsp_data.door_belief = door_in;
      rsp_data.status_led  = (door_in == DOOR_OPEN);
      rsp_data.opener      = opener_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_prev_ff  <= 1'b1;
         button_prev_ff   <= 1'b1;
         press_ticks_ff   <= '0;
         press_seen_ff    <= 1'b0;
         door_ff          <= DOOR_UNKNOWN;
         last_cmd_ff      <= CMD_NONE;
         opener_ff        <= SRC_NONE;
         suppress_left_ff <= '0;
         pulse_left_ff    <= '0;
      end else if (step_en) begin
         trigger_prev_ff  <= trigger_prev_in;
         button_prev_ff   <= button_prev_in;
         press_ticks_ff   <= press_ticks_in;
         press_seen_ff    <= press_seen_in;
         door_ff          <= door_in;
         last_cmd_ff      <= last_cmd_in;
         opener_ff        <= opener_in;
         suppress_left_ff <= suppress_left_in;
         pulse_left_ff    <= pulse_left_in;
      end
   end

endmodule
`default_nettype wire

/* sv/door_toggle_controller.sv */
// Top level of the door toggle controller.
// Each input beat is one millisecond tick and yields exactly one result beat. The tick is
// decided from the beat and the stored controller state, and the result is held in an
// output register, so one beat is taken every cycle unless stalled, and its result
// appears in the next cycle. The input side is ready whenever the output register is
// empty or is being drained in the same cycle. Configuration writes are taken at once.
`default_nettype none
module door_toggle_controller import dtc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtc_req_if.sink   req_if,
   dtc_rsp_if.source rsp_if,
   dtc_csr_if.sink   csr_if
);

   cfg_type      cfg;
   rsp_data_type tick_rsp;
   logic         step_en;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   dtc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   dtc_tick u_tick (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .cfg      (cfg),
      .req_data (req_if.data),
      .rsp_data (tick_rsp)
   );

   assign req_if.ready = ~rsp_valid_ff | rsp_if.ready;
   assign step_en      = req_if.valid & req_if.ready;
   assign rsp_valid_in = step_en | (rsp_valid_ff & ~rsp_if.ready);

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= tick_rsp;
      end
   end

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench of the door toggle controller, predicting every result beat.
`timescale 1ns / 1ps
module testbench;
   import dtc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned RANDOM_ITEMS = 1250;
   localparam int unsigned PHASES       = 8;

   logic clock;
   logic reset;

   dtc_req_if req_ch ();
   dtc_rsp_if rsp_ch ();
   dtc_csr_if csr_ch ();

   door_toggle_controller uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   cfg_type                  cfg;
   logic                     trig_prev;
   logic                     btn_prev;
   logic                     press_on;
   logic [PressWidth-1:0]    press_len;
   logic [1:0]               door_now;
   logic [1:0]               last_cmd;
   logic [1:0]               opened_by;
   logic [SuppressWidth-1:0] suppress_left;
   logic [PulseWidth-1:0]    pulse_left;

   rsp_data_type predicted_outputs[$];
   int unsigned  mismatches;
   int unsigned  cycle_count;
   int unsigned  ticks_sent;
   int unsigned  hold_cycles;
   int unsigned  stall_left;
   bit           gaps_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function rsp_data_type decide_tick(req_data_type d);
      rsp_data_type r;
      logic         trig_fall;
      logic         btn_press;
      logic         btn_rel;
      logic         btn_ok;
      logic         fire;
      logic         open_cmd;
      logic         to_close;
      r        = '0;
      fire     = 1'b0;
      open_cmd = 1'b0;
      btn_ok   = 1'b0;
      if (press_on && press_len != PRESS_SAT) press_len = press_len + 1'b1;
      if (pulse_left != '0) begin
         pulse_left = pulse_left - 1'b1;
         r.relay_on = 1'b1;
      end else begin
         trig_fall = trig_prev & ~d.trigger_level;
         btn_press = btn_prev & ~d.button_level;
         btn_rel   = ~btn_prev & d.button_level;
         if (suppress_left != '0) suppress_left = suppress_left - 1'b1;
         if (btn_press) begin
            press_len = '0;
            press_on  = 1'b1;
         end else if (btn_rel) begin
            btn_ok    = press_on && press_len > PRESS_MIN && press_len < PRESS_MAX;
            press_on  = 1'b0;
            press_len = '0;
         end
         trig_prev = d.trigger_level;
         btn_prev  = d.button_level;
         if (trig_fall || btn_ok) begin
            to_close = (last_cmd == CMD_OPEN) || (last_cmd == CMD_NONE && door_now == DOOR_OPEN);
            fire          = 1'b1;
            open_cmd      = ~to_close;
            door_now      = to_close ? DOOR_CLOSED : DOOR_OPEN;
            last_cmd      = to_close ? CMD_CLOSE : CMD_OPEN;
            opened_by     = trig_fall ? SRC_TRIGGER : SRC_BUTTON;
            suppress_left = cfg.suppress_ms;
         end
         if (!fire && d.auto_open_req) begin
            if (cfg.hold_open || suppress_left != '0) begin
               r.auto_refused = 1'b1;
            end else begin
               fire      = 1'b1;
               open_cmd  = 1'b1;
               door_now  = DOOR_OPEN;
               opened_by = SRC_AUTO;
               last_cmd  = CMD_OPEN;
            end
         end
         if (!fire && d.auto_close_req) begin
            if (cfg.hold_open) begin
               r.auto_refused = 1'b1;
            end else begin
               fire      = 1'b1;
               open_cmd  = 1'b0;
               door_now  = DOOR_CLOSED;
               opened_by = SRC_NONE;
               last_cmd  = CMD_CLOSE;
            end
         end
         if (fire) begin
            if (cfg.radio_present && d.radio_accepted) begin
               r.send_open  = open_cmd;
               r.send_close = ~open_cmd;
            end else begin
               pulse_left = (cfg.pulse_ms == '0) ? '0 : cfg.pulse_ms - 1'b1;
               r.relay_on = 1'b1;
            end
         end
      end
      r.status_led  = (door_now == DOOR_OPEN);
      r.door_belief = door_now;
      r.opener      = opened_by;
      return r;
   endfunction

   function int unsigned pick_gap();
      int unsigned roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function req_data_type pack_tick(logic t, logic b, logic ao, logic ac, logic acc);
      req_data_type d;
      d.trigger_level  = t;
      d.button_level   = b;
      d.auto_open_req  = ao;
      d.auto_close_req = ac;
      d.radio_accepted = acc;
      return d;
   endfunction

   function req_data_type make_tick(logic t, logic b);
      return pack_tick(t, b, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) != 0);
   endfunction

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_outputs.size() == 0) begin
               if (mismatches < 10)
                  $display("cycle %0d: result beat with nothing expected", cycle_count);
               mismatches++;
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_ch.data.send_open !== want.send_open ||
                   rsp_ch.data.send_close !== want.send_close ||
                   rsp_ch.data.relay_on !== want.relay_on ||
                   rsp_ch.data.status_led !== want.status_led ||
                   rsp_ch.data.door_belief !== want.door_belief ||
                   rsp_ch.data.opener !== want.opener ||
                   rsp_ch.data.auto_refused !== want.auto_refused) begin
                  if (mismatches < 10)
                     $display({"cycle %0d: expected open %b close %b relay %b led %b door %0d ",
                               "opener %0d refused %b, got open %b close %b relay %b led %b ",
                               "door %0d opener %0d refused %b"},
                              cycle_count, want.send_open, want.send_close, want.relay_on,
                              want.status_led, want.door_belief, want.opener,
                              want.auto_refused, rsp_ch.data.send_open,
                              rsp_ch.data.send_close, rsp_ch.data.relay_on,
                              rsp_ch.data.status_led, rsp_ch.data.door_belief,
                              rsp_ch.data.opener, rsp_ch.data.auto_refused);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) predicted_outputs.push_back(decide_tick(req_ch.data));
      end
   end

   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles--;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL door_toggle_controller");
         $finish;
      end
   end

   task automatic send_tick(req_data_type d);
      int unsigned gap;
      req_ch.valid <= 1'b1;
      req_ch.data  <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{index: idx, wdata: value};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_HOLD_OPEN:     cfg.hold_open     = value[0];
         CSR_RADIO_PRESENT: cfg.radio_present = value[0];
         CSR_SUPPRESS_MS:   cfg.suppress_ms   = value[SuppressWidth-1:0];
         CSR_PULSE_MS:      cfg.pulse_ms      = value[PulseWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic hold, logic radio, int unsigned supp, int unsigned pulse);
      set_reg(CSR_HOLD_OPEN, hold);
      set_reg(CSR_RADIO_PRESENT, radio);
      set_reg(CSR_SUPPRESS_MS, supp);
      set_reg(CSR_PULSE_MS, pulse);
   endtask

   // Every beat sent here falls inside the running pulse, so all of it must be ignored.
   task automatic drain_pulse();
      wait_idle();
      repeat (pulse_left) send_tick(make_tick($urandom_range(0, 1), $urandom_range(0, 1)));
      wait_idle();
   endtask

   task automatic test_reset_values();
      send_tick(pack_tick(1, 1, 0, 0, 1));
      send_tick(pack_tick(0, 1, 0, 0, 1));
      repeat (305) send_tick(make_tick($urandom_range(0, 1), $urandom_range(0, 1)));
      drain_pulse();
   endtask

   task automatic test_directed();
      set_config(0, 1, 2, 2);
      drain_pulse();
      send_tick(pack_tick(1, 1, 0, 0, 1));
      send_tick(pack_tick(0, 1, 1, 1, 1));
      send_tick(pack_tick(1, 1, 1, 1, 1));
      send_tick(pack_tick(1, 1, 1, 0, 1));
      send_tick(pack_tick(1, 1, 0, 1, 0));
      send_tick(pack_tick(0, 0, 1, 1, 1));
      send_tick(pack_tick(0, 1, 0, 0, 1));
      send_tick(pack_tick(1, 1, 0, 0, 0));
      set_reg(CSR_HOLD_OPEN, 1);
      drain_pulse();
      send_tick(pack_tick(1, 1, 1, 0, 1));
      send_tick(pack_tick(1, 1, 0, 1, 1));
      send_tick(pack_tick(1, 1, 1, 1, 1));
      send_tick(pack_tick(0, 1, 1, 1, 1));
      set_config(0, 0, 2, 0);
      send_tick(pack_tick(1, 1, 0, 1, 1));
      send_tick(pack_tick(1, 1, 1, 0, 1));
      send_tick(pack_tick(1, 1, 0, 0, 0));
      set_config(0, 1, 0, 1);
      send_tick(pack_tick(0, 1, 1, 1, 1));
      send_tick(pack_tick(1, 1, 1, 0, 1));
      send_tick(pack_tick(1, 0, 0, 0, 1));
      send_tick(pack_tick(0, 1, 0, 0, 1));
      wait_idle();
   endtask

   task automatic test_press_limits();
      int unsigned press_lens[6] = '{29, 30, 31, 1499, 1500, 2060};
      set_config(0, 1, 0, 1);
      drain_pulse();
      gaps_on = 1'b0;
      send_tick(pack_tick(1, 1, 0, 0, 1));
      foreach (press_lens[i]) begin
         repeat (press_lens[i]) send_tick(pack_tick(1, 0, 0, 0, 1));
         send_tick(pack_tick(1, 1, 0, 0, 1));
         send_tick(pack_tick(1, 1, 0, 0, 1));
      end
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_long_pulse();
      set_config(0, 1, 600000, 5000);
      drain_pulse();
      gaps_on = 1'b0;
      send_tick(pack_tick(1, 1, 0, 0, 1));
      send_tick(pack_tick(0, 1, 0, 0, 0));
      drain_pulse();
      send_tick(pack_tick(1, 1, 1, 0, 1));
      send_tick(pack_tick(1, 1, 0, 1, 1));
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_config(0, 1, 5, 1);
      drain_pulse();
      gaps_on     = 1'b0;
      hold_cycles = 300;
      repeat (80) send_tick(make_tick($urandom_range(0, 1), $urandom_range(0, 1)));
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_random();
      int unsigned phase_end;
      int unsigned kind;
      int unsigned roll;
      int unsigned press_hold;
      int unsigned supp;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            set_config(0, 1, 0, 1);
         end else if (phase == 1) begin
            set_config(1, 1, 600000, 1);
         end else if (phase == 2) begin
            set_config(0, 0, 3, 0);
         end else begin
            roll = $urandom_range(0, 2);
            supp = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(1, 20) : $urandom_range(20, 200);
            set_config($urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0, supp,
                       $urandom_range(0, 4));
         end
         drain_pulse();
         gaps_on   = ($urandom_range(0, 3) != 0);
         phase_end = ticks_sent + RANDOM_ITEMS / PHASES;
         while (ticks_sent < phase_end) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
               repeat ($urandom_range(1, 4)) send_tick(make_tick(0, 1));
               repeat ($urandom_range(1, 3)) send_tick(make_tick(1, 1));
            end else if (kind < 6) begin
               roll = $urandom_range(0, 9);
               press_hold = (roll < 6) ? $urandom_range(26, 36) :
                            (roll < 8) ? $urandom_range(1, 10) : $urandom_range(37, 120);
               repeat (press_hold) send_tick(make_tick(1, 0));
               repeat ($urandom_range(1, 3)) send_tick(make_tick(1, 1));
            end else if (kind < 9) begin
               repeat ($urandom_range(1, 6)) send_tick(make_tick(1, 1));
            end else begin
               repeat ($urandom_range(1, 5))
                  send_tick(make_tick($urandom_range(0, 1), $urandom_range(0, 1)));
            end
         end
         gaps_on = 1'b1;
         wait_idle();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      gaps_on       = 1'b1;
      mismatches    = 0;
      cycle_count   = 0;
      ticks_sent    = 0;
      hold_cycles   = 0;
      stall_left    = 0;
      cfg           = '{hold_open: 1'b0, radio_present: 1'b0,
                        suppress_ms: SUPPRESS_RESET, pulse_ms: PULSE_RESET};
      trig_prev     = 1'b1;
      btn_prev      = 1'b1;
      press_on      = 1'b0;
      press_len     = '0;
      door_now      = DOOR_UNKNOWN;
      last_cmd      = CMD_NONE;
      opened_by     = SRC_NONE;
      suppress_left = '0;
      pulse_left    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed();
      test_press_limits();
      test_long_pulse();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && predicted_outputs.size() == 0) begin
         $display("PASS door_toggle_controller");
      end else begin
         $display("FAIL door_toggle_controller");
      end
      $finish;
   end

endmodule
